// ===== src/ntt_pkg.sv =====
// ntt_pkg: shared types and constants for the nearest timestamp table
// request/result structs, item kinds, status codes, default sizes
`timescale 1ns / 1ps

package ntt_pkg;

  localparam int DefaultDepth    = 1024;
  localparam int DefaultTimeBits = 48;

  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_INSERT  = 2'd1;
  localparam logic [1:0] KIND_NEAREST = 2'd2;
  localparam logic [1:0] KIND_MEDIAN  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] time_us;
    logic [47:0] tolerance_us;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  match_index;
    logic [47:0] period_us;
    logic [10:0] entry_count;
  } res_t;

endpackage

// ===== src/ntt_ram.sv =====
// ntt_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module ntt_ram #(
  parameter int Width = 48,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/nearest_timestamp_table_core.sv =====
// nearest_timestamp_table_core: sorted timestamp table with nearest and median queries
// depends on ntt_pkg and ntt_ram
//
//   channel   ports                  direction  meaning
//   request   start, busy, req_i     in         clear / insert / nearest / median
//   result    valid_o, res_o         out        one result per request, one cycle
//
// clear, a full insert, a nearest on an empty table and a median of under two entries
// answer straight from idle; an insert reads and shifts each larger entry up one slot,
// then writes the new time; a nearest runs a binary lower bound search (up to
// floor(log2 n) + 1 steps), then compares the lower neighbor when it stops inside the
// table above slot 0; a median runs a bitwise search of the median gap that rescans
// the table once per bit. reset empties the table at once (no clearing pass). the
// receiver cannot stall: a result shows for exactly one cycle while busy is already low.
`timescale 1ns / 1ps

module nearest_timestamp_table_core #(
  parameter int TableDepth = ntt_pkg::DefaultDepth,
  parameter int TimeBits   = ntt_pkg::DefaultTimeBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ntt_pkg::req_t req_i,
  output logic          valid_o,
  output ntt_pkg::res_t res_o
);

  localparam int CW = $clog2(TableDepth + 1);
  localparam int AW = $clog2(TableDepth);
  localparam int TW = TimeBits;
  localparam int BW = $clog2(TimeBits);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INS_RD = 4'd1;
  localparam logic [3:0] S_INS_CM = 4'd2;
  localparam logic [3:0] S_NR_SR  = 4'd3;
  localparam logic [3:0] S_NR_SW  = 4'd4;
  localparam logic [3:0] S_NR_AW  = 4'd5;
  localparam logic [3:0] S_NR_BW  = 4'd6;
  localparam logic [3:0] S_NR_SEL = 4'd7;
  localparam logic [3:0] S_NR_TOL = 4'd8;
  localparam logic [3:0] S_MED    = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] n_q, n_d;
  logic [TW-1:0] t_q, t_d, tol_q, tol_d;
  logic [CW-1:0] pos_q, pos_d, hi_q, hi_d, mid_q, mid_d;
  logic          chk_q, chk_d;
  logic [TW-1:0] prev_q, prev_d, before_q, before_d, after_q, after_d;
  logic [TW-1:0] diff_q, diff_d;
  logic [CW-1:0] ridx_q, ridx_d, cnt_q, cnt_d, k_q, k_d;
  logic          rv_q, rv_d, rfirst_q, rfirst_d, dv_q, dv_d;
  logic [TW-1:0] pref_q, pref_d, cand_q, cand_d;
  logic [BW-1:0] bit_q, bit_d;
  ntt_pkg::res_t res_q, res_d;
  logic          valid_q, valid_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [TW-1:0] wdata, rdata;
  logic [CW-1:0] mid_c;
  logic [TW-1:0] pref_n;

  ntt_ram #(
    .Width(TW),
    .Depth(TableDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    t_d      = t_q;
    tol_d    = tol_q;
    pos_d    = pos_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    chk_d    = chk_q;
    prev_d   = prev_q;
    before_d = before_q;
    after_d  = after_q;
    diff_d   = diff_q;
    ridx_d   = ridx_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    rv_d     = 1'b0;
    rfirst_d = rfirst_q;
    dv_d     = 1'b0;
    pref_d   = pref_q;
    cand_d   = cand_q;
    bit_d    = bit_q;
    res_d    = res_q;
    valid_d  = 1'b0;
    we       = 1'b0;
    waddr    = AW'(pos_q);
    wdata    = t_q;
    raddr    = '0;
    mid_c    = CW'(({1'b0, pos_q} + {1'b0, hi_q}) >> 1);
    pref_n   = pref_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          t_d   = TW'(req_i.time_us);
          tol_d = TW'(req_i.tolerance_us);
          res_d = '0;
          res_d.entry_count = 11'(n_q);
          case (req_i.kind)
            ntt_pkg::KIND_CLEAR: begin
              n_d = '0;
              res_d.entry_count = '0;
              valid_d = 1'b1;
            end
            ntt_pkg::KIND_INSERT: begin
              if (n_q >= CW'(TableDepth)) begin
                res_d.status = ntt_pkg::ST_FULL;
                valid_d = 1'b1;
              end else begin
                pos_d   = n_q;
                state_d = S_INS_RD;
              end
            end
            ntt_pkg::KIND_NEAREST: begin
              if (n_q == '0) begin
                res_d.status = ntt_pkg::ST_MISS;
                valid_d = 1'b1;
              end else begin
                pos_d   = '0;
                hi_d    = n_q;
                state_d = S_NR_SR;
              end
            end
            default: begin
              if (n_q >= CW'(2)) begin
                k_d      = (n_q - CW'(1)) >> 1;
                bit_d    = BW'(TW - 1);
                pref_d   = '0;
                cand_d   = ~({TW{1'b1}} << (TW - 1));
                ridx_d   = '0;
                cnt_d    = '0;
                state_d  = S_MED;
              end else begin
                valid_d = 1'b1;
              end
            end
          endcase
        end
      end

      // shift larger entries up one slot, then drop the new time in
      S_INS_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          n_d     = n_q + CW'(1);
          res_d.entry_count = 11'(n_q + CW'(1));
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          raddr   = AW'(pos_q - CW'(1));
          state_d = S_INS_CM;
        end
      end

      S_INS_CM: begin
        we = 1'b1;
        if (rdata > t_q) begin
          wdata   = rdata;
          pos_d   = pos_q - CW'(1);
          state_d = S_INS_RD;
        end else begin
          n_d     = n_q + CW'(1);
          res_d.entry_count = 11'(n_q + CW'(1));
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      // lower bound search, pos_q is lo
      S_NR_SR: begin
        if (pos_q < hi_q) begin
          raddr   = AW'(mid_c);
          mid_d   = mid_c;
          state_d = S_NR_SW;
        end else begin
          if (pos_q == n_q) begin
            mid_d = n_q - CW'(1);
            chk_d = 1'b0;
          end else begin
            mid_d = pos_q;
            chk_d = (pos_q != '0);
          end
          raddr   = AW'(mid_d);
          state_d = S_NR_AW;
        end
      end

      S_NR_SW: begin
        if (rdata < t_q) begin
          pos_d = mid_q + CW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = S_NR_SR;
      end

      S_NR_AW: begin
        if (chk_q) begin
          prev_d  = rdata;
          raddr   = AW'(mid_q - CW'(1));
          state_d = S_NR_BW;
        end else begin
          diff_d  = (rdata >= t_q) ? rdata - t_q : t_q - rdata;
          state_d = S_NR_TOL;
        end
      end

      S_NR_BW: begin
        before_d = t_q - rdata;
        after_d  = prev_q - t_q;
        state_d  = S_NR_SEL;
      end

      // earlier neighbor wins a tie
      S_NR_SEL: begin
        if (before_q <= after_q) begin
          mid_d  = mid_q - CW'(1);
          diff_d = before_q;
        end else begin
          diff_d = after_q;
        end
        state_d = S_NR_TOL;
      end

      S_NR_TOL: begin
        if (diff_q <= tol_q) begin
          res_d.match_index = 10'(mid_q);
        end else begin
          res_d.status = ntt_pkg::ST_MISS;
        end
        valid_d = 1'b1;
        state_d = S_IDLE;
      end

      // one pass per bit: count gaps at or below the candidate
      S_MED: begin
        if (ridx_q < n_q) begin
          raddr    = AW'(ridx_q);
          ridx_d   = ridx_q + CW'(1);
          rv_d     = 1'b1;
          rfirst_d = (ridx_q == '0);
        end
        if (rv_q) begin
          prev_d = rdata;
          if (!rfirst_q) begin
            diff_d = rdata - prev_q;
            dv_d   = 1'b1;
          end
        end
        if (dv_q && (diff_q <= cand_q)) begin
          cnt_d = cnt_q + CW'(1);
        end
        if ((ridx_q == n_q) && !rv_q && !dv_q) begin
          if (cnt_q <= k_q) begin
            pref_n = pref_q | (TW'(1) << bit_q);
          end
          pref_d = pref_n;
          if (bit_q == '0) begin
            res_d.period_us = 48'(pref_n);
            valid_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            bit_d  = bit_q - BW'(1);
            cand_d = pref_n | ~({TW{1'b1}} << (bit_q - BW'(1)));
            ridx_d = '0;
            cnt_d  = '0;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      valid_q <= 1'b0;
      rv_q    <= 1'b0;
      dv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      valid_q <= valid_d;
      rv_q    <= rv_d;
      dv_q    <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    tol_q    <= tol_d;
    pos_q    <= pos_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    chk_q    <= chk_d;
    prev_q   <= prev_d;
    before_q <= before_d;
    after_q  <= after_d;
    diff_q   <= diff_d;
    ridx_q   <= ridx_d;
    cnt_q    <= cnt_d;
    k_q      <= k_d;
    rfirst_q <= rfirst_d;
    pref_q   <= pref_d;
    cand_q   <= cand_d;
    bit_q    <= bit_d;
    res_q    <= res_d;
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== tb/testbench.sv =====
// testbench: checks nearest_timestamp_table_core against a sorted-queue predictor
// depends on ntt_pkg and the core; random requests with gaps, directed edge cases
`timescale 1ns / 1ps

module testbench;

  localparam int Depth     = 1024;
  localparam int CycleLimit = 2000000;
  localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

  class ts_scoreboard;
    logic [47:0]   held_times[$];
    ntt_pkg::res_t expected_q[$];
    int            errors;

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void note(ntt_pkg::req_t r);
      ntt_pkg::res_t e;
      int          pos;
      int          lo;
      int          hi;
      int          mid;
      int          n;
      logic [47:0] after_d;
      logic [47:0] before_d;
      logic [47:0] gap_dist;
      logic [47:0] gap;
      logic [47:0] gaps[$];
      e = '0;
      n = held_times.size();
      case (r.kind)
        ntt_pkg::KIND_CLEAR: begin
          held_times.delete();
        end
        ntt_pkg::KIND_INSERT: begin
          if (n >= Depth) begin
            e.status = ntt_pkg::ST_FULL;
          end else begin
            pos = n;
            while (pos > 0 && held_times[pos-1] > r.time_us) pos--;
            held_times.insert(pos, r.time_us);
          end
        end
        ntt_pkg::KIND_NEAREST: begin
          if (n == 0) begin
            e.status = ntt_pkg::ST_MISS;
          end else begin
            lo = 0;
            hi = n;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (held_times[mid] < r.time_us) lo = mid + 1;
              else hi = mid;
            end
            if (lo == n) begin
              lo = n - 1;
            end else if (lo > 0) begin
              after_d  = held_times[lo] - r.time_us;
              before_d = r.time_us - held_times[lo-1];
              if (before_d <= after_d) lo--;
            end
            gap_dist = (held_times[lo] >= r.time_us) ? held_times[lo] - r.time_us
                                                     : r.time_us - held_times[lo];
            if (gap_dist > r.tolerance_us) e.status = ntt_pkg::ST_MISS;
            else e.match_index = lo[9:0];
          end
        end
        default: begin
          if (n >= 2) begin
            for (int i = 0; i < n - 1; i++) begin
              gap = held_times[i+1] - held_times[i];
              pos = gaps.size();
              while (pos > 0 && gaps[pos-1] > gap) pos--;
              gaps.insert(pos, gap);
            end
            e.period_us = gaps[(n-1)/2];
          end
        end
      endcase
      e.entry_count = 11'(held_times.size());
      expected_q = {expected_q, e};
    endfunction

    task check(ntt_pkg::res_t r);
      ntt_pkg::res_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", r));
        return;
      end
      e = expected_q.pop_front();
      if (r.status !== e.status)
        report($sformatf("status %0d, want %0d", r.status, e.status));
      if (r.match_index !== e.match_index)
        report($sformatf("match_index %0d, want %0d", r.match_index, e.match_index));
      if (r.period_us !== e.period_us)
        report($sformatf("period_us %0d, want %0d", r.period_us, e.period_us));
      if (r.entry_count !== e.entry_count)
        report($sformatf("entry_count %0d, want %0d", r.entry_count, e.entry_count));
    endtask
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  ntt_pkg::req_t req_i;
  logic          valid_o;
  ntt_pkg::res_t res_o;
  int            cycles;
  bit            no_idle;
  logic [47:0]   cluster_base;
  ts_scoreboard  table_sb;

  nearest_timestamp_table_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) table_sb.check(res_o);
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
  endfunction

  // hold the request until it is taken, then idle for a random gap that may be zero
  task automatic send(logic [1:0] kind, logic [47:0] t, logic [47:0] tol);
    int gap;
    int sel;
    logic [127:0] junk;
    req_i.kind         = kind;
    req_i.time_us      = t;
    req_i.tolerance_us = tol;
    start              = 1'b1;
    do @(posedge clk_i); while (busy);
    table_sb.note(req_i);
    @(negedge clk_i);
    sel = $urandom_range(0, 99);
    if (no_idle || sel < 65) gap = 0;
    else if (sel < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start = 1'b0;
      junk  = {$urandom(), $urandom(), $urandom(), $urandom()};
      req_i = junk[$bits(ntt_pkg::req_t)-1:0];
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic logic [47:0] pick_time();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return rand48();
    if (sel == 1) return TimeMax - 48'($urandom_range(0, 3));
    return cluster_base + 48'($urandom_range(0, 4000));
  endfunction

  function automatic logic [47:0] pick_tol();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return TimeMax;
      2: return rand48();
      default: return 48'($urandom_range(0, 600));
    endcase
  endfunction

  initial begin
    int sel;
    int n;
    table_sb = new();
    cycles  = 0;
    no_idle = 1'b0;
    start   = 1'b0;
    req_i   = '0;
    rst_ni  = 1'b0;
    cluster_base = 48'd1000;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table, extremes, duplicates and ties
    send(ntt_pkg::KIND_MEDIAN, '0, '0);
    send(ntt_pkg::KIND_NEAREST, 48'd5, TimeMax);
    send(ntt_pkg::KIND_INSERT, TimeMax, '0);
    send(ntt_pkg::KIND_MEDIAN, '0, '0);
    send(ntt_pkg::KIND_INSERT, '0, '0);
    send(ntt_pkg::KIND_INSERT, '0, TimeMax);
    send(ntt_pkg::KIND_MEDIAN, '0, '0);
    send(ntt_pkg::KIND_NEAREST, TimeMax, '0);
    send(ntt_pkg::KIND_NEAREST, 48'h7FFF_FFFF_FFFF, TimeMax);
    send(ntt_pkg::KIND_NEAREST, 48'h8000_0000_0000, TimeMax);
    send(ntt_pkg::KIND_NEAREST, 48'd1, '0);
    send(ntt_pkg::KIND_NEAREST, 48'd1, 48'd1);
    send(ntt_pkg::KIND_INSERT, 48'd100, '0);
    send(ntt_pkg::KIND_INSERT, 48'd200, '0);
    send(ntt_pkg::KIND_NEAREST, 48'd150, 48'd50);
    send(ntt_pkg::KIND_NEAREST, 48'd150, 48'd49);
    send(ntt_pkg::KIND_MEDIAN, '0, '0);
    send(ntt_pkg::KIND_CLEAR, rand48(), rand48());
    send(ntt_pkg::KIND_NEAREST, 48'd100, TimeMax);

    // fill to capacity in ascending order so no entries shift
    no_idle = 1'b1;
    for (int i = 0; i < Depth; i++) begin
      send(ntt_pkg::KIND_INSERT, 48'd1000 + 48'(i) * 48'd7, '0);
    end
    no_idle = 1'b0;
    send(ntt_pkg::KIND_INSERT, 48'd5, '0);
    send(ntt_pkg::KIND_INSERT, TimeMax, '0);
    send(ntt_pkg::KIND_NEAREST, TimeMax, TimeMax);
    send(ntt_pkg::KIND_NEAREST, 48'd1000 + 48'd7 * 48'd1023, '0);
    send(ntt_pkg::KIND_MEDIAN, '0, '0);
    send(ntt_pkg::KIND_CLEAR, '0, '0);

    for (int k = 0; k < 580; k++) begin
      if (k % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
      n = table_sb.held_times.size();
      sel = $urandom_range(0, 99);
      if (sel < 2 || (n > 50 && sel < 10)) begin
        cluster_base = rand48() & 48'h7FFF_FFFF_FFFF;
        send(ntt_pkg::KIND_CLEAR, rand48(), rand48());
      end else if (sel < 50) begin
        send(ntt_pkg::KIND_INSERT, pick_time(), rand48());
      end else if (sel < 88) begin
        send(ntt_pkg::KIND_NEAREST, pick_time(), pick_tol());
      end else begin
        send(ntt_pkg::KIND_MEDIAN, rand48(), rand48());
      end
    end

    start = 1'b0;
    while (table_sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (table_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== nearest_timestamp_table_core.f =====
src/ntt_pkg.sv
src/ntt_ram.sv
src/nearest_timestamp_table_core.sv
tb/testbench.sv
